// ===== hw/rtl/wtpq_pkg.sv =====
package wtpq_pkg;

  localparam int WIN_LEN_W = 16;
  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 16'd10;

  typedef struct packed {
    logic sods_level;
    logic soe_level;
    logic lo_level;
    logic change_ack;
  } in_word_t;

  typedef struct packed {
    logic sods_state;
    logic soe_state;
    logic lo_state;
    logic any_changed;
    logic window_done;
  } out_word_t;

  typedef struct packed {
    logic step;
    logic close;
  } pin_ctrl_t;

endpackage

// ===== hw/rtl/wtpq_pin.sv =====
module wtpq_pin #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wtpq_pkg::pin_ctrl_t           ctrl,
  input  logic                          level,
  input  logic [wtpq_pkg::WIN_LEN_W-1:0] window_length,
  output logic                          qual_high
);
  import wtpq_pkg::*;

  localparam int CntW  = COUNT_WIDTH + 1;
  localparam int ProdW = (CntW + 4 > WIN_LEN_W + 4) ? CntW + 4 : WIN_LEN_W + 4;

  logic [CntW-1:0]  count_r;
  logic [CntW-1:0]  count_nxt;
  logic [CntW-1:0]  added;
  logic [ProdW-1:0] cnt_ext;
  logic [ProdW-1:0] wl_ext;
  logic [ProdW-1:0] cnt_x10;
  logic [ProdW-1:0] wl_x9;

  // The high count saturates at all ones.
  assign added = (level && (count_r != {CntW{1'b1}})) ? count_r + CntW'(1) : count_r;

  assign cnt_ext   = ProdW'(added);
  assign wl_ext    = ProdW'(window_length);
  assign cnt_x10   = (cnt_ext << 3) + (cnt_ext << 1);
  assign wl_x9     = (wl_ext << 3) + wl_ext;
  assign qual_high = cnt_x10 > wl_x9;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.step) begin
      count_nxt = ctrl.close ? '0 : added;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/windowed_three_pin_qualifier.sv =====
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid / in_stall | wtpq_pkg::in_word_t
// out     | output    | out_valid/out_stall | wtpq_pkg::out_word_t
// cfg     | input     | cfg_we              | window_length, 16 bits
//
// A word goes through two registers: the input register, then the result register.
// One word is taken every cycle while in_stall is low.
// Reset is synchronous and restores window_length to 10 and clears all counts and flags.
// in_stall rises only while both registers hold words and out_stall is high.
module windowed_three_pin_qualifier #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wtpq_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wtpq_pkg::out_word_t           out_data,
  input  logic                          cfg_we,
  input  logic [wtpq_pkg::WIN_LEN_W-1:0] cfg_wdata
);
  import wtpq_pkg::*;

  localparam int CmpW = (COUNT_WIDTH > WIN_LEN_W) ? COUNT_WIDTH : WIN_LEN_W;

  logic [WIN_LEN_W-1:0]   window_length_r;
  logic                   s1_valid_r;
  in_word_t               s1_word_r;
  logic                   out_valid_r;
  out_word_t              out_word_r;
  out_word_t              out_word_nxt;
  logic [COUNT_WIDTH-1:0] tick_count_r;
  logic [COUNT_WIDTH-1:0] tick_count_nxt;
  logic [2:0]             qual_r;
  logic [2:0]             qual_nxt;
  logic [2:0]             qual_new;
  logic                   change_flag_r;
  logic                   change_flag_nxt;
  logic                   advance;
  logic                   close;
  pin_ctrl_t              pin_ctrl;

  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign advance   = s1_valid_r && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign close = !(CmpW'(tick_count_r) < CmpW'(window_length_r));

  assign pin_ctrl.step  = advance;
  assign pin_ctrl.close = close;

  wtpq_pin #(.COUNT_WIDTH(COUNT_WIDTH)) u_pin_sods (
    .clk(clk), .rst_n(rst_n), .ctrl(pin_ctrl), .level(s1_word_r.sods_level),
    .window_length(window_length_r), .qual_high(qual_new[2])
  );

  wtpq_pin #(.COUNT_WIDTH(COUNT_WIDTH)) u_pin_soe (
    .clk(clk), .rst_n(rst_n), .ctrl(pin_ctrl), .level(s1_word_r.soe_level),
    .window_length(window_length_r), .qual_high(qual_new[1])
  );

  wtpq_pin #(.COUNT_WIDTH(COUNT_WIDTH)) u_pin_lo (
    .clk(clk), .rst_n(rst_n), .ctrl(pin_ctrl), .level(s1_word_r.lo_level),
    .window_length(window_length_r), .qual_high(qual_new[0])
  );

  // The acknowledge clears the flag before this word's change detection sets it.
  always_comb begin
    tick_count_nxt  = close ? '0 : tick_count_r + COUNT_WIDTH'(1);
    qual_nxt        = close ? qual_new : qual_r;
    change_flag_nxt = (change_flag_r && !s1_word_r.change_ack) ||
                      (close && (qual_new != qual_r));
    out_word_nxt.sods_state  = qual_nxt[2];
    out_word_nxt.soe_state   = qual_nxt[1];
    out_word_nxt.lo_state    = qual_nxt[0];
    out_word_nxt.any_changed = change_flag_nxt;
    out_word_nxt.window_done = close;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WIN_LEN_RESET;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      tick_count_r    <= '0;
      qual_r          <= '0;
      change_flag_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length_r <= cfg_wdata;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        tick_count_r  <= tick_count_nxt;
        qual_r        <= qual_nxt;
        change_flag_r <= change_flag_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word_r <= in_data;
    end
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

// ===== tb/sv/tb_windowed_three_pin_qualifier.sv =====
`timescale 1ns / 1ps

module tb_windowed_three_pin_qualifier;
  import wtpq_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we;
  logic [WIN_LEN_W-1:0] cfg_wdata;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int errors = 0;

  logic [WIN_LEN_W-1:0] win_len;
  logic [15:0]          tick_cnt;
  logic [16:0]          high_cnt [3];
  logic [2:0]           qual;
  logic                 chg_flag;

  out_word_t expected_states [$];
  out_word_t exp_w;

  windowed_three_pin_qualifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Levels are indexed with the first signal pin at bit 2 and lift-off at bit 0.
  function automatic out_word_t next_qualified_state(in_word_t w);
    out_word_t  r;
    logic [2:0] lv;
    logic [2:0] nq;
    r = '0;
    lv = {w.sods_level, w.soe_level, w.lo_level};
    if (w.change_ack) chg_flag = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (lv[i] && high_cnt[i] != '1) high_cnt[i] = high_cnt[i] + 1'b1;
    end
    if (tick_cnt < win_len) begin
      tick_cnt = tick_cnt + 1'b1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        nq[i] = (10 * int'(high_cnt[i])) > (9 * int'(win_len));
        high_cnt[i] = '0;
      end
      if (nq != qual) chg_flag = 1'b1;
      qual = nq;
      tick_cnt = '0;
      r.window_done = 1'b1;
    end
    r.sods_state = qual[2];
    r.soe_state = qual[1];
    r.lo_state = qual[0];
    r.any_changed = chg_flag;
    return r;
  endfunction

  task automatic check_bit(input string name, input logic e, input logic a);
    if (e !== a) begin
      $display("%0t: %s expected %0b, got %0b", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_states.push_back(next_qualified_state(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_states.size() == 0) begin
          $display("%0t: result word %b arrived with nothing expected", $time, out_data);
          errors++;
        end else begin
          exp_w = expected_states.pop_front();
          check_bit("sods_state", exp_w.sods_state, out_data.sods_state);
          check_bit("soe_state", exp_w.soe_state, out_data.soe_state);
          check_bit("lo_state", exp_w.lo_state, out_data.lo_state);
          check_bit("any_changed", exp_w.any_changed, out_data.any_changed);
          check_bit("window_done", exp_w.window_done, out_data.window_done);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  function automatic in_word_t pick_word(int sods_pct, int soe_pct, int lo_pct, int ack_pct);
    in_word_t w;
    w.sods_level = ($urandom_range(99) < sods_pct);
    w.soe_level = ($urandom_range(99) < soe_pct);
    w.lo_level = ($urandom_range(99) < lo_pct);
    w.change_ack = ($urandom_range(99) < ack_pct);
    return w;
  endfunction

  // Entered and left at a falling edge; valid stays high for a following word.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_states.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(input logic [WIN_LEN_W-1:0] len);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_len = len;
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // The reset window of ten ticks closes on the eleventh word; ten highs of eleven
  // qualify and nine do not.
  task automatic test_default_window();
    for (int i = 0; i < 11; i++) begin
      send_word(pick_word(100, (i == 0) ? 0 : 100, (i < 2) ? 0 : 100, 0));
    end
  endtask

  // With a zero length every word closes a window, including one that acknowledges
  // and changes a level at once.
  task automatic test_zero_window();
    write_window(16'd0);
    send_word(pick_word(100, 100, 100, 0));
    send_word(pick_word(0, 0, 0, 100));
    send_word(pick_word(0, 0, 0, 100));
    send_word(pick_word(100, 0, 100, 0));
  endtask

  task automatic test_min_window();
    write_window(16'd1);
    send_word(pick_word(0, 100, 0, 100));
    send_word(pick_word(0, 0, 0, 0));
  endtask

  task automatic test_shortened_window();
    write_window(16'hFFFF);
    for (int i = 0; i < 5; i++) send_word(pick_word(100, 100, 100, 0));
    write_window(16'd2);
    send_word(pick_word(0, 100, 0, 100));
  endtask

  task automatic test_random_windows();
    int pct [3];
    int levels [6] = '{0, 3, 50, 90, 97, 100};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) set_idling(11, 45);
      else if (ph < 6) set_idling(45, 11);
      else set_idling(0, 0);
      write_window((ph == 0) ? 16'd1 : 16'($urandom_range(1, 20)));
      for (int n = 0; n < 50; n++) begin
        if (n % 12 == 0) begin
          for (int k = 0; k < 3; k++) pct[k] = levels[$urandom_range(5)];
        end
        send_word(pick_word(pct[0], pct[1], pct[2], 15));
        if (ph == 4 && n == 25) drain_results();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    win_len = WIN_LEN_RESET;
    tick_cnt = '0;
    for (int i = 0; i < 3; i++) high_cnt[i] = '0;
    qual = '0;
    chg_flag = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(11, 45);
    test_default_window();
    test_zero_window();
    test_min_window();
    test_shortened_window();
    test_random_windows();

    drain_results();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
